>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DefaultDepth = 16;
  localparam int OpW          = 2;
  localparam int ValueW       = 32;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

endpackage

>>> rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for deque operations and deque results.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::OpW-1:0]      op;
  logic signed [deq_pkg::ValueW-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface deq_out_if #(
  parameter int CountW = $clog2(deq_pkg::DefaultDepth + 1)
);
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::ValueW-1:0]   popped_value;
  logic                                popped_valid;
  logic                                rejected;
  logic signed [deq_pkg::ValueW-1:0]   front_value;
  logic signed [deq_pkg::ValueW-1:0]   back_value;
  logic        [CountW-1:0]            entry_count;
  logic                                is_empty;

  modport source (output valid, output popped_value, output popped_valid, output rejected,
                  output front_value, output back_value, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input popped_value, input popped_valid, input rejected,
                  input front_value, input back_value, input entry_count,
                  input is_empty, output ready);
endinterface

>>> rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values in a ring memory of DEPTH slots.
// ----------------------------------------------------------------------------
// in_ch carries one operation per transfer: push back, push front, pop back
// or pop front, with the value to push. out_ch returns one result per
// operation: popped value, refusal flag, front and back values after the
// operation (all ones when empty), count and empty flag.
// The accept cycle updates head and count, writes a pushed value, and
// issues a read of the slot that becomes the new front or back after a
// pop; the result register loads once the output register is free.
// The front and back values are kept in registers beside the ring memory,
// so each operation needs at most one memory read.
// in_ch.ready is low while an operation waits for the result register. A
// finished result waits in the output register while the next operation is
// accepted; when the receiver stalls, at most one more operation is taken.
// Reset empties the deque at once; slot contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic signed [ValueW-1:0] mem [DEPTH];

  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [ValueW-1:0]    front_q, front_d, back_q, back_d;
  logic                 pend_q;
  logic [ValueW-1:0]    pend_popped_q, popped_d;
  logic                 pend_pvalid_q, pvalid_d;
  logic                 pend_rej_q, rej_d;
  logic                 ld_front_q, ld_front_d, ld_back_q, ld_back_d;
  logic [ValueW-1:0]    rdata_q;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic                 accept, done, full, empty;
  logic [ValueW-1:0]    front_fin, back_fin;

  logic                 out_valid_q;
  logic [ValueW-1:0]    out_popped_q, out_front_q, out_back_q;
  logic                 out_pvalid_q, out_rej_q, out_empty_q;
  logic [CW-1:0]        out_count_q;

  assign in_ch.ready = !pend_q;
  assign accept      = in_ch.valid && !pend_q;
  assign done        = pend_q && (!out_valid_q || out_ch.ready);
  assign full        = count_q == CW'(DEPTH);
  assign empty       = count_q == '0;

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    front_d    = front_q;
    back_d     = back_q;
    popped_d   = '0;
    pvalid_d   = 1'b0;
    rej_d      = 1'b0;
    ld_front_d = 1'b0;
    ld_back_d  = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = ring_add(head_q, count_q);
    raddr      = head_q;
    unique case (op_e'(in_ch.op))
      OP_PUSH_BACK: begin
        if (full) begin
          rej_d = 1'b1;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
          back_d  = in_ch.value;
          if (empty) begin
            front_d = in_ch.value;
          end
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          rej_d = 1'b1;
        end else begin
          head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
          waddr   = head_d;
          we      = 1'b1;
          count_d = count_q + CW'(1);
          front_d = in_ch.value;
          if (empty) begin
            back_d = in_ch.value;
          end
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          rej_d = 1'b1;
        end else begin
          popped_d = back_q;
          pvalid_d = 1'b1;
          count_d  = count_q - CW'(1);
          if (count_q == CW'(2)) begin
            back_d = front_q;
          end else if (count_q > CW'(2)) begin
            re        = 1'b1;
            ld_back_d = 1'b1;
            raddr     = ring_add(head_q, count_q - CW'(2));
          end
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          rej_d = 1'b1;
        end else begin
          popped_d = front_q;
          pvalid_d = 1'b1;
          count_d  = count_q - CW'(1);
          head_d   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
          if (count_q == CW'(2)) begin
            front_d = back_q;
          end else if (count_q > CW'(2)) begin
            re         = 1'b1;
            ld_front_d = 1'b1;
            raddr      = head_d;
          end
        end
      end
      default: begin
        rej_d = 1'b1;
      end
    endcase
  end

  // ring memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (accept && we) begin
      mem[waddr] <= in_ch.value;
    end
    if (accept && re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign front_fin = ld_front_q ? rdata_q : front_q;
  assign back_fin  = ld_back_q  ? rdata_q : back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
        pend_q  <= 1'b1;
      end else if (done) begin
        pend_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      front_q       <= front_d;
      back_q        <= back_d;
      pend_popped_q <= popped_d;
      pend_pvalid_q <= pvalid_d;
      pend_rej_q    <= rej_d;
      ld_front_q    <= ld_front_d;
      ld_back_q     <= ld_back_d;
    end else if (done) begin
      front_q    <= front_fin;
      back_q     <= back_fin;
      ld_front_q <= 1'b0;
      ld_back_q  <= 1'b0;
    end
    if (done) begin
      out_popped_q <= pend_popped_q;
      out_pvalid_q <= pend_pvalid_q;
      out_rej_q    <= pend_rej_q;
      out_front_q  <= empty ? '1 : front_fin;
      out_back_q   <= empty ? '1 : back_fin;
      out_count_q  <= count_q;
      out_empty_q  <= empty;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.popped_value = out_popped_q;
  assign out_ch.popped_valid = out_pvalid_q;
  assign out_ch.rejected     = out_rej_q;
  assign out_ch.front_value  = out_front_q;
  assign out_ch.back_value   = out_back_q;
  assign out_ch.entry_count  = out_count_q;
  assign out_ch.is_empty     = out_empty_q;

endmodule

>>> tb/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the double-ended queue. A directed table covers
// refused pops after reset, pushes and pops of extreme values at both ends,
// a fill to capacity and refused pushes when full. Random bursts follow that
// lean toward pushes, pops or neither, so the ring keeps crossing empty and
// full. Every transfer accepted on the operation channel is run through a
// local ring predictor, and each result transfer is compared field by field
// with the oldest prediction. Sender and receiver idle at random, and the
// receiver holds off for long stretches so the block stalls its input.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int Depth      = DefaultDepth;
  localparam int CountW     = $clog2(Depth + 1);
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;
  localparam int PhaseItems = 620;
  localparam logic [ValueW-1:0] EmptyValue = '1;

  typedef struct packed {
    logic [ValueW-1:0] popped_value;
    logic              popped_valid;
    logic              rejected;
    logic [ValueW-1:0] front_value;
    logic [ValueW-1:0] back_value;
    logic [CountW-1:0] entry_count;
    logic              is_empty;
  } status_t;

  typedef struct packed {
    op_e               op;
    logic [ValueW-1:0] value;
    logic              typed;
    status_t           want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  deq_in_if                     op_ch ();
  deq_out_if #(.CountW(CountW)) res_ch ();

  double_ended_queue_top #(.DEPTH(Depth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (op_ch),
    .out_ch (res_ch)
  );

  logic [ValueW-1:0] ring_mdl [Depth];
  int                head_mdl;
  int                count_mdl;
  status_t           expected_status_q [$];
  stim_row_t         dir_tbl [$];
  int                err_count;
  int                cycle_cnt;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_reqs;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic status_t deque_apply(op_e op, logic [ValueW-1:0] v);
    status_t r;
    r = '0;
    r.front_value = EmptyValue;
    r.back_value  = EmptyValue;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (count_mdl == Depth) begin
          r.rejected = 1'b1;
        end else if (op == OP_PUSH_BACK) begin
          ring_mdl[(head_mdl + count_mdl) % Depth] = v;
          count_mdl++;
        end else begin
          head_mdl = (head_mdl + Depth - 1) % Depth;
          ring_mdl[head_mdl] = v;
          count_mdl++;
        end
      end
      default: begin
        if (count_mdl == 0) begin
          r.rejected = 1'b1;
        end else if (op == OP_POP_BACK) begin
          r.popped_value = ring_mdl[(head_mdl + count_mdl - 1) % Depth];
          r.popped_valid = 1'b1;
          count_mdl--;
        end else begin
          r.popped_value = ring_mdl[head_mdl];
          r.popped_valid = 1'b1;
          head_mdl = (head_mdl + 1) % Depth;
          count_mdl--;
        end
      end
    endcase
    if (count_mdl != 0) begin
      r.front_value = ring_mdl[head_mdl];
      r.back_value  = ring_mdl[(head_mdl + count_mdl - 1) % Depth];
    end
    r.entry_count = CountW'(count_mdl);
    r.is_empty    = (count_mdl == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ValueW-1:0] got, logic [ValueW-1:0] want);
    err_count++;
    if (err_count <= 100) begin
      $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
  endtask

  task automatic send_op(op_e op, logic [ValueW-1:0] v, logic typed, status_t want);
    status_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      op_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.op    <= op;
    op_ch.value <= v;
    @(posedge clk_i);
    while (!op_ch.ready) @(posedge clk_i);
    pred = deque_apply(op, v);
    expected_status_q.push_back(typed ? want : pred);
  endtask

  task automatic run_random(int n_items);
    int                left;
    int                burst;
    int                push_pct;
    op_e               op;
    logic [ValueW-1:0] v;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(40, 4);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (burst) begin
        if (left > 0) begin
          if ($urandom_range(99) < push_pct) begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          end else begin
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
          end
          case ($urandom_range(9))
            0:       v = 32'h7fff_ffff;
            1:       v = 32'h8000_0000;
            2:       v = '0;
            3:       v = '1;
            default: v = $urandom();
          endcase
          send_op(op, v, 1'b0, '0);
          left--;
        end
      end
    end
  endtask

  task automatic long_hold_burst();
    hold_reqs++;
    repeat (24) send_op(OP_PUSH_BACK, $urandom(), 1'b0, '0);
  endtask

  // result side: ready pattern, long hold-offs and checking
  initial begin
    int      seen_reqs;
    int      hold_left;
    status_t got;
    status_t want;
    seen_reqs = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.popped_value, res_ch.popped_valid, res_ch.rejected,
                res_ch.front_value, res_ch.back_value, res_ch.entry_count,
                res_ch.is_empty};
        if (expected_status_q.size() == 0) begin
          report_mismatch("unexpected result", got.popped_value, '0);
        end else begin
          want = expected_status_q.pop_front();
          if (got.popped_value !== want.popped_value)
            report_mismatch("popped_value", got.popped_value, want.popped_value);
          if (got.popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", ValueW'(got.popped_valid),
                            ValueW'(want.popped_valid));
          if (got.rejected !== want.rejected)
            report_mismatch("rejected", ValueW'(got.rejected), ValueW'(want.rejected));
          if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
          if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", ValueW'(got.entry_count),
                            ValueW'(want.entry_count));
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", ValueW'(got.is_empty), ValueW'(want.is_empty));
        end
      end
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    err_count     = 0;
    head_mdl      = 0;
    count_mdl     = 0;
    hold_reqs     = 0;
    send_idle_pct = 10;
    recv_idle_pct = 82;
    rst_ni      <= 1'b0;
    op_ch.valid <= 1'b0;
    op_ch.op    <= OP_PUSH_BACK;
    op_ch.value <= '0;

    dir_tbl = '{
      '{OP_POP_BACK,   32'hffff_ffff, 1'b1,
        '{32'h0, 1'b0, 1'b1, EmptyValue, EmptyValue, 5'd0, 1'b1}},
      '{OP_POP_FRONT,  32'h1234_5678, 1'b1,
        '{32'h0, 1'b0, 1'b1, EmptyValue, EmptyValue, 5'd0, 1'b1}},
      '{OP_PUSH_BACK,  32'h7fff_ffff, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 5'd1, 1'b0}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
        '{32'h0, 1'b0, 1'b0, 32'h8000_0000, 32'h7fff_ffff, 5'd2, 1'b0}},
      '{OP_POP_BACK,   32'h0000_0000, 1'b1,
        '{32'h7fff_ffff, 1'b1, 1'b0, 32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0}},
      '{OP_POP_FRONT,  32'hffff_ffff, 1'b1,
        '{32'h8000_0000, 1'b1, 1'b0, EmptyValue, EmptyValue, 5'd0, 1'b1}},
      '{OP_PUSH_BACK,  32'hffff_ffff, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
      '{OP_PUSH_BACK,  32'haaaa_aaaa, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h8000_0000, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h7fff_ffff, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0000_0001, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hffff_fffe, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0f0f_0f0f, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hf0f0_f0f0, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h00ff_00ff, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hff00_ff00, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h1357_9bdf, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h2468_ace0, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'hdead_0001, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h0bad_f00d, 1'b0, '0},
      '{OP_PUSH_BACK,  32'h1111_1111, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h2222_2222, 1'b0, '0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_op(dir_tbl[i].op, dir_tbl[i].value, dir_tbl[i].typed, dir_tbl[i].want);
    end

    long_hold_burst();
    run_random(PhaseItems);

    send_idle_pct = 82;
    recv_idle_pct = 10;
    run_random(PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_burst();
    run_random(PhaseItems);

    op_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_status_q.size() != 0) begin
      report_mismatch("results left over", ValueW'(expected_status_q.size()), '0);
    end

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> double_ended_queue_top.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/double_ended_queue_top.sv
tb/double_ended_queue_top_tb.sv
